[sv/life_automaton_row_step_unit_assert.svh]
// Assertion macros for the life row step unit; empty bodies under synthesis
`ifndef LIFE_AUTOMATON_ROW_STEP_UNIT_ASSERT_SVH
`define LIFE_AUTOMATON_ROW_STEP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk_i, off during reset
`define LRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, clocked on clk_i, off during reset
`define LRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LRS_ASSERT_IMPL(lbl, ante, cons, msg)
`define LRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/lrs_pkg.sv]
// Shared constants, types and helpers for the life row step unit
`timescale 1ns / 1ps
package lrs_pkg;

  // field widths
  localparam int CELL_W     = 64;
  localparam int CFG_W      = 7;
  localparam int POP_W      = 7;
  localparam int TOTAL_W    = 17;

  // active grid width, at most CELL_W
  localparam int ROW_WIDTH  = 64;

  // lane split of one row
  localparam int LANE_COUNT = 8;
  localparam int LANE_W     = CELL_W / LANE_COUNT;
  localparam int CNT_W      = $clog2(LANE_W + 1);

  localparam logic [CFG_W-1:0]   WIDTH_RESET = CFG_W'(64);
  localparam logic [TOTAL_W-1:0] POP_MAX     = {TOTAL_W{1'b1}};

  // what the lane stage hands to the merge stage
  typedef struct packed {
    logic [CELL_W-1:0]                       cells;
    logic [LANE_COUNT-1:0][CNT_W-1:0]        counts;
    logic                                    frame_end;
  } lrs_s1_t;

  // columns at or above min(width, ROW_WIDTH) are dead
  function automatic logic [CELL_W-1:0] active_mask(input logic [CFG_W-1:0] width);
    logic [CELL_W-1:0] m;
    m = '0;
    for (int j = 0; j < CELL_W; j++) begin
      m[j] = (j < int'(width)) && (j < ROW_WIDTH);
    end
    return m;
  endfunction

endpackage

[sv/lrs_if.sv]
// Valid/ready channel interfaces: row input, result output, width config
`timescale 1ns / 1ps
interface lrs_in_if;
  import lrs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] row_cells;
  logic              last_row;
  modport source (output valid, row_cells, last_row, input ready);
  modport sink   (input valid, row_cells, last_row, output ready);
endinterface

interface lrs_out_if;
  import lrs_pkg::*;
  logic               valid;
  logic               ready;
  logic [CELL_W-1:0]  next_row_cells;
  logic [POP_W-1:0]   row_population;
  logic [TOTAL_W-1:0] frame_population;
  logic               frame_end;
  modport source (output valid, next_row_cells, row_population, frame_population,
                  frame_end, input ready);
  modport sink   (input valid, next_row_cells, row_population, frame_population,
                  frame_end, output ready);
endinterface

interface lrs_cfg_if;
  import lrs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] width_in_use;
  modport source (output valid, width_in_use, input ready);
  modport sink   (input valid, width_in_use, output ready);
endinterface

[sv/lrs_lane.sv]
// One lane: B3/S23 next state and live count for a slice of columns
`timescale 1ns / 1ps
module lrs_lane (
  input  logic [lrs_pkg::LANE_W+1:0] up_i,
  input  logic [lrs_pkg::LANE_W+1:0] mid_i,
  input  logic [lrs_pkg::LANE_W+1:0] dn_i,
  input  logic [lrs_pkg::LANE_W-1:0] mask_i,
  output logic [lrs_pkg::LANE_W-1:0] cells_o,
  output logic [lrs_pkg::CNT_W-1:0]  count_o
);
  import lrs_pkg::*;

  // windows carry one neighbor column on each side; cell c sits at c+1
  // the column just past the active width can see a birth, so mask it here
  always_comb begin
    logic [3:0] sum;
    for (int c = 0; c < LANE_W; c++) begin
      sum = 4'(up_i[c])  + 4'(up_i[c+1])  + 4'(up_i[c+2])
          + 4'(mid_i[c]) + 4'(mid_i[c+1]) + 4'(mid_i[c+2])
          + 4'(dn_i[c])  + 4'(dn_i[c+1])  + 4'(dn_i[c+2]);
      cells_o[c] = ((sum == 4'd3) || ((sum == 4'd4) && mid_i[c+1])) && mask_i[c];
    end
  end

  // live cells in this lane
  always_comb begin
    count_o = '0;
    for (int c = 0; c < LANE_W; c++) begin
      count_o = count_o + CNT_W'(cells_o[c]);
    end
  end

endmodule

[sv/lrs_merge.sv]
// Merge stage: lane counts to row population, running frame total, output register
`timescale 1ns / 1ps
module lrs_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s1_valid_i,
  input  lrs_pkg::lrs_s1_t     s1_i,
  output logic                 s1_take_o,
  lrs_out_if.source            out_o
);
  import lrs_pkg::*;

  logic                 out_valid_q, out_valid_d;
  logic [CELL_W-1:0]    cells_q;
  logic [POP_W-1:0]     row_pop_q;
  logic [TOTAL_W-1:0]   frame_pop_q;
  logic                 end_q;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [POP_W-1:0]     row_pop;
  logic [TOTAL_W:0]     total_sum;
  logic [TOTAL_W-1:0]   total_sat;
  logic                 load;

  // add up the lane counts
  always_comb begin
    row_pop = '0;
    for (int k = 0; k < LANE_COUNT; k++) begin
      row_pop = row_pop + POP_W'(s1_i.counts[k]);
    end
  end

  // running total, saturating
  assign total_sum = (TOTAL_W+1)'(total_q) + (TOTAL_W+1)'(row_pop);
  assign total_sat = total_sum[TOTAL_W] ? POP_MAX : total_sum[TOTAL_W-1:0];

  assign s1_take_o = !out_valid_q || out_o.ready;
  assign load      = s1_take_o && s1_valid_i;

  always_comb begin
    out_valid_d = out_valid_q;
    total_d     = total_q;
    if (s1_take_o) begin
      out_valid_d = s1_valid_i;
    end
    if (load) begin
      total_d = s1_i.frame_end ? '0 : total_sat;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      cells_q     <= s1_i.cells;
      row_pop_q   <= row_pop;
      frame_pop_q <= total_sat;
      end_q       <= s1_i.frame_end;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.next_row_cells   = cells_q;
  assign out_o.row_population   = row_pop_q;
  assign out_o.frame_population = frame_pop_q;
  assign out_o.frame_end        = end_q;

endmodule

[sv/life_automaton_row_step_unit.sv]
// Life row step unit: one B3/S23 generation over a row-streamed grid.
//
// Channels: in_i takes one grid row per item (row_cells, last_row) in raster
// order; out_o gives one result per row of the next generation, with the row
// population and a running frame population; cfg_i writes width_in_use.
// The first row of a frame is stored and gives no result unless it ends the
// frame; each further row gives the next state of the row above it. The last
// row also gives its own next state: a frame of N rows gives N results, the
// last with frame_end. A result passes the lane stage register and then the
// output register on its way to out_o.
// Throughput: one row per cycle while out_o takes results. The extra result of
// the last row takes a lane stage slot of its own, with in_i.ready low.
// Eight lanes of eight columns each compute the next row in parallel; the
// merge stage sums their counts and keeps the frame total.
// Reset: width_in_use returns to 64, frame state and pipeline are cleared.
// When out_o stalls, the output and lane registers hold and in_i.ready drops
// once both are full; nothing is lost or repeated. The user must write
// configuration only between items with no result pending, unchecked by the unit.
`timescale 1ns / 1ps
`include "life_automaton_row_step_unit_assert.svh"
module life_automaton_row_step_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrs_in_if.sink     in_i,
  lrs_out_if.source  out_o,
  lrs_cfg_if.sink    cfg_i
);
  import lrs_pkg::*;

  logic [CFG_W-1:0]  width_q;
  logic [CELL_W-1:0] mask;

  logic [CELL_W-1:0] above_q, above_d;
  logic [CELL_W-1:0] middle_q, middle_d;
  logic              mid_valid_q, mid_valid_d;
  logic              flush_q, flush_d;

  logic              s1_valid_q, s1_valid_d;
  lrs_s1_t           s1_q, s1_gen;
  logic              s1_ready;
  logic              s1_take;

  logic              in_fire;
  logic [CELL_W-1:0] row_m;
  logic [CELL_W-1:0] sel_up, sel_mid, sel_dn;
  logic              gen_valid, gen_end;
  logic [CELL_W+1:0] pad_up, pad_mid, pad_dn;

  logic              last_fire;
  logic              frame_idle;
  logic              pop_ok;

  // width register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (cfg_i.valid) begin
      width_q <= cfg_i.width_in_use;
    end
  end

  assign mask     = active_mask(width_q);
  assign row_m    = in_i.row_cells & mask;
  assign s1_ready = !s1_valid_q || s1_take;
  assign in_i.ready = s1_ready && !flush_q;
  assign in_fire  = in_i.valid && in_i.ready;

  // pick the three rows for the lanes and whether a result is made
  always_comb begin
    sel_up    = above_q;
    sel_mid   = middle_q;
    sel_dn    = row_m;
    gen_valid = in_fire;
    gen_end   = 1'b0;
    if (flush_q) begin
      sel_dn    = '0;
      gen_valid = s1_ready;
      gen_end   = 1'b1;
    end else if (!mid_valid_q) begin
      sel_up    = '0;
      sel_mid   = row_m;
      sel_dn    = '0;
      gen_valid = in_fire && in_i.last_row;
      gen_end   = 1'b1;
    end
  end

  // dead border on both sides of the row
  assign pad_up  = {1'b0, sel_up & mask, 1'b0};
  assign pad_mid = {1'b0, sel_mid & mask, 1'b0};
  assign pad_dn  = {1'b0, sel_dn & mask, 1'b0};

  // lanes
  for (genvar k = 0; k < LANE_COUNT; k++) begin : g_lane
    logic [LANE_W-1:0] lane_cells;
    lrs_lane u_lane (
      .up_i    (pad_up[k*LANE_W +: LANE_W+2]),
      .mid_i   (pad_mid[k*LANE_W +: LANE_W+2]),
      .dn_i    (pad_dn[k*LANE_W +: LANE_W+2]),
      .mask_i  (mask[k*LANE_W +: LANE_W]),
      .cells_o (lane_cells),
      .count_o (s1_gen.counts[k])
    );
    assign s1_gen.cells[k*LANE_W +: LANE_W] = lane_cells;
  end
  assign s1_gen.frame_end = gen_end;

  // frame state sequencing
  always_comb begin
    above_d     = above_q;
    middle_d    = middle_q;
    mid_valid_d = mid_valid_q;
    flush_d     = flush_q;
    if (flush_q) begin
      if (s1_ready) begin
        above_d     = '0;
        middle_d    = '0;
        mid_valid_d = 1'b0;
        flush_d     = 1'b0;
      end
    end else if (in_fire) begin
      if (!mid_valid_q) begin
        above_d = '0;
        if (in_i.last_row) begin
          middle_d = '0;
        end else begin
          middle_d    = row_m;
          mid_valid_d = 1'b1;
        end
      end else begin
        above_d  = middle_q & mask;
        middle_d = row_m;
        flush_d  = in_i.last_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q     <= '0;
      middle_q    <= '0;
      mid_valid_q <= 1'b0;
      flush_q     <= 1'b0;
    end else begin
      above_q     <= above_d;
      middle_q    <= middle_d;
      mid_valid_q <= mid_valid_d;
      flush_q     <= flush_d;
    end
  end

  // lane stage register
  assign s1_valid_d = s1_ready ? gen_valid : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && gen_valid) begin
      s1_q <= s1_gen;
    end
  end

  // merge stage and output register
  lrs_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid_q),
    .s1_i       (s1_q),
    .s1_take_o  (s1_take),
    .out_o      (out_o)
  );

  // checks
  assign last_fire  = in_fire && in_i.last_row;
  assign frame_idle = !mid_valid_q && !flush_q;
  assign pop_ok     = out_o.frame_population >= TOTAL_W'(out_o.row_population);

  `LRS_ASSERT_NEXT(a_last_row_flush, last_fire && mid_valid_q, flush_q, "no final result")
  `LRS_ASSERT_NEXT(a_single_row_frame, last_fire && !mid_valid_q, frame_idle, "state kept")
  `LRS_ASSERT_NEXT(a_flush_clears, flush_q && s1_ready, frame_idle, "frame not cleared")
  `LRS_ASSERT_IMPL(a_total_covers_row, out_o.valid, pop_ok, "frame total below row pop")

endmodule

[tb/tb.sv]
// Self-checking testbench for the life row step unit: table rows, random frames, idle phases
`timescale 1ns / 1ps
module tb;
  import lrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WIDTH_ANY      = -1;
  localparam int LONG_FRAME     = 150;
  localparam logic [CELL_W-1:0] EVERY_THIRD = 64'h9249_2492_4924_9249;

  // one result item of the next generation
  typedef struct packed {
    logic [CELL_W-1:0]  cells;
    logic [POP_W-1:0]   pop;
    logic [TOTAL_W-1:0] total;
    logic               fin;
  } gen_result_t;

  // one row of the directed table; fixed rows carry their single result
  typedef struct packed {
    logic [CELL_W-1:0]  cells;
    logic               last;
    logic               fixed;
    logic [CELL_W-1:0]  want_cells;
    logic [POP_W-1:0]   want_pop;
    logic [TOTAL_W-1:0] want_total;
  } seed_row_t;

  localparam int SEED_COUNT = 20;
  localparam seed_row_t SEED_ROWS [SEED_COUNT] = '{
    // single-row frames, next state between dead rows
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 7'd62, 17'd62},
    '{64'h0, 1'b1, 1'b1, 64'h0, 7'd0, 17'd0},
    '{64'h7, 1'b1, 1'b1, 64'h2, 7'd1, 17'd1},
    '{64'h8000_0000_0000_0001, 1'b1, 1'b1, 64'h0, 7'd0, 17'd0},
    // blinker
    '{64'h0, 1'b0, 1'b0, '0, '0, '0},
    '{64'h7, 1'b0, 1'b0, '0, '0, '0},
    '{64'h0, 1'b1, 1'b0, '0, '0, '0},
    // block still life
    '{64'h3, 1'b0, 1'b0, '0, '0, '0},
    '{64'h3, 1'b1, 1'b0, '0, '0, '0},
    // dead centre with four live neighbors stays dead
    '{64'h5, 1'b0, 1'b0, '0, '0, '0},
    '{64'h0, 1'b0, 1'b0, '0, '0, '0},
    '{64'h5, 1'b1, 1'b0, '0, '0, '0},
    // full grid
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0, '0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0, '0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, '0, '0, '0},
    // cells on both border columns
    '{64'hC000_0000_0000_0003, 1'b0, 1'b0, '0, '0, '0},
    '{64'h8000_0000_0000_0001, 1'b0, 1'b0, '0, '0, '0},
    '{64'hC000_0000_0000_0003, 1'b1, 1'b0, '0, '0, '0},
    // checkerboard
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0, '0, '0},
    '{64'h5555_5555_5555_5555, 1'b1, 1'b0, '0, '0, '0}
  };

  // random phases: width, sender idle %, receiver stall %, rows
  typedef struct packed {
    int width;
    int src_idle;
    int sink_stall;
    int rows;
  } phase_t;

  localparam int PHASE_COUNT = 8;
  localparam phase_t PHASES [PHASE_COUNT] = '{
    '{0,         0,  0,  60},
    '{1,         50, 0,  60},
    '{127,       0,  50, 100},
    '{64,        10, 10, 150},
    '{WIDTH_ANY, 0,  0,  120},
    '{65,        50, 0,  100},
    '{WIDTH_ANY, 0,  50, 120},
    '{63,        10, 10, 150}
  };

  logic clk;
  logic rst_n;

  lrs_in_if  row_ch ();
  lrs_out_if res_ch ();
  lrs_cfg_if cfg_ch ();

  life_automaton_row_step_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (row_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // predictor state
  logic [CFG_W-1:0]   width_now;
  logic [CELL_W-1:0]  above_cells;
  logic [CELL_W-1:0]  middle_cells;
  logic               middle_held;
  logic [TOTAL_W-1:0] frame_total;
  gen_result_t        pending_results[$];

  int src_idle;
  int sink_stall;
  int errors;
  int rows_sent;
  int results_seen;
  int frames_sent;
  int idle_cycles;
  bit saturated;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // live columns for a given width register value
  function automatic logic [CELL_W-1:0] width_mask(input logic [CFG_W-1:0] w);
    int lim;
    lim = (int'(w) > ROW_WIDTH) ? ROW_WIDTH : int'(w);
    if (lim >= CELL_W) return '1;
    return (64'd1 << lim) - 64'd1;
  endfunction

  // B3/S23 with the centre counted in the 3x3 sum
  function automatic logic [CELL_W-1:0] life_step(input logic [CELL_W-1:0] up,
                                                  input logic [CELL_W-1:0] mid,
                                                  input logic [CELL_W-1:0] dn,
                                                  input logic [CELL_W-1:0] m);
    logic [CELL_W+1:0] pu, pm, pd;
    logic [CELL_W-1:0] nxt;
    int sum;
    pu = {1'b0, up & m, 1'b0};
    pm = {1'b0, mid & m, 1'b0};
    pd = {1'b0, dn & m, 1'b0};
    nxt = '0;
    for (int j = 0; j < CELL_W; j++) begin
      sum = 0;
      for (int k = j; k < j + 3; k++) sum += int'(pu[k]) + int'(pm[k]) + int'(pd[k]);
      nxt[j] = (sum == 3) || (sum == 4 && pm[j+1]);
    end
    return nxt & m;
  endfunction

  // book one expected result and advance the frame total
  task automatic book_result(input logic [CELL_W-1:0] cells, input logic fin);
    gen_result_t r;
    int pop;
    int tot;
    pop = $countones(cells);
    tot = int'(frame_total) + pop;
    if (tot >= int'(POP_MAX)) begin
      tot = int'(POP_MAX);
      saturated = 1'b1;
    end
    frame_total = TOTAL_W'(tot);
    r.cells = cells;
    r.pop   = POP_W'(pop);
    r.total = frame_total;
    r.fin   = fin;
    pending_results.push_back(r);
  endtask

  task automatic clear_frame();
    above_cells  = '0;
    middle_cells = '0;
    middle_held  = 1'b0;
    frame_total  = '0;
  endtask

  // predict the results of one accepted row
  task automatic predict_row(input logic [CELL_W-1:0] cells, input logic last);
    logic [CELL_W-1:0] m;
    logic [CELL_W-1:0] r;
    m = width_mask(width_now);
    r = cells & m;
    if (!middle_held) begin
      above_cells  = '0;
      middle_cells = r;
      middle_held  = 1'b1;
      if (last) begin
        book_result(life_step('0, r, '0, m), 1'b1);
        clear_frame();
      end
    end else begin
      book_result(life_step(above_cells, middle_cells, r, m), 1'b0);
      above_cells  = middle_cells & m;
      middle_cells = r;
      if (last) begin
        book_result(life_step(above_cells, middle_cells, '0, m), 1'b1);
        clear_frame();
      end
    end
    if (last) frames_sent++;
  endtask

  // offer one row, with random gaps, and predict it once accepted
  task automatic put_row(input logic [CELL_W-1:0] cells, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      row_ch.valid <= 1'b0;
      @(negedge clk);
    end
    row_ch.valid     <= 1'b1;
    row_ch.row_cells <= cells;
    row_ch.last_row  <= last;
    do @(posedge clk); while (!row_ch.ready);
    predict_row(cells, last);
    rows_sent++;
  endtask

  // stop offering rows and wait for every expected result
  task automatic drain();
    @(negedge clk);
    row_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write the width register while the unit is idle
  task automatic write_width(input logic [CFG_W-1:0] w);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.width_in_use <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    width_now = w;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // random frames, mostly short, with varied cell density
  task automatic run_frames(input int rows);
    int left;
    int len;
    int style;
    logic [CELL_W-1:0] cells;
    left = rows;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (len > left) len = left;
      style = $urandom_range(3);
      for (int k = 0; k < len; k++) begin
        cells = {$urandom, $urandom};
        if (style == 1) cells &= {$urandom, $urandom};
        else if (style == 2) cells |= {$urandom, $urandom};
        else if (style == 3 && $urandom_range(3) == 0) cells = $urandom_range(1) ? '1 : '0;
        put_row(cells, k == len - 1);
      end
      left -= len;
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= sink_stall);
  end

  // result check and watchdog
  always @(posedge clk) begin
    gen_result_t want;
    if (rst_n) begin
      if ((row_ch.valid && row_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: watchdog, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("RESULT: ERROR");
          $finish;
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, cells %h", $time, res_ch.next_row_cells);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (res_ch.next_row_cells !== want.cells) begin
            $display("%0t: next_row_cells expected %h got %h", $time, want.cells,
                     res_ch.next_row_cells);
            errors++;
          end
          if (res_ch.row_population !== want.pop) begin
            $display("%0t: row_population expected %0d got %0d", $time, want.pop,
                     res_ch.row_population);
            errors++;
          end
          if (res_ch.frame_population !== want.total) begin
            $display("%0t: frame_population expected %0d got %0d", $time, want.total,
                     res_ch.frame_population);
            errors++;
          end
          if (res_ch.frame_end !== want.fin) begin
            $display("%0t: frame_end expected %0b got %0b", $time, want.fin,
                     res_ch.frame_end);
            errors++;
          end
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    gen_result_t fixed_res;
    int w;
    rst_n               = 1'b0;
    row_ch.valid        = 1'b0;
    row_ch.row_cells    = '0;
    row_ch.last_row     = 1'b0;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.width_in_use = '0;
    src_idle     = 0;
    sink_stall   = 0;
    errors       = 0;
    rows_sent    = 0;
    results_seen = 0;
    frames_sent  = 0;
    idle_cycles  = 0;
    saturated    = 1'b0;
    width_now    = WIDTH_RESET;
    clear_frame();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table at the reset width
    for (int i = 0; i < SEED_COUNT; i++) begin
      put_row(SEED_ROWS[i].cells, SEED_ROWS[i].last);
      if (SEED_ROWS[i].fixed) begin
        void'(pending_results.pop_back());
        fixed_res.cells = SEED_ROWS[i].want_cells;
        fixed_res.pop   = SEED_ROWS[i].want_pop;
        fixed_res.total = SEED_ROWS[i].want_total;
        fixed_res.fin   = 1'b1;
        pending_results.push_back(fixed_res);
      end
    end

    // random phases over widths and idle patterns
    for (int p = 0; p < PHASE_COUNT; p++) begin
      w = (PHASES[p].width == WIDTH_ANY) ? $urandom_range(2, 62) : PHASES[p].width;
      write_width(CFG_W'(w));
      src_idle   = PHASES[p].src_idle;
      sink_stall = PHASES[p].sink_stall;
      run_frames(PHASES[p].rows);
    end

    // one long frame of repeated EVERY_THIRD rows at full width
    write_width(CFG_W'(64));
    src_idle   = 0;
    sink_stall = 10;
    for (int k = 0; k < LONG_FRAME; k++) begin
      put_row(EVERY_THIRD, k == LONG_FRAME - 1);
    end

    drain();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("Covered %0d rows in %0d frames, %0d results, widths 0 to 127, four idle mixes.",
             rows_sent, frames_sent, results_seen);
    $display("Frame population saturation reached: %0s, mismatches: %0d.",
             saturated ? "yes" : "no", errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/lrs_pkg.sv
sv/lrs_if.sv
sv/lrs_lane.sv
sv/lrs_merge.sv
sv/life_automaton_row_step_unit.sv
tb/tb.sv
